// ===== rtl/ieq_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types and constants of the input event ring queue.
package ieq_pkg;

  // Default queue depth
  localparam int unsigned IEQ_DEPTH = 64;

  // Width of the queue count in a result beat
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_MOUSE = 2'd1,
    REQ_POP   = 2'd2,
    REQ_CLEAR = 2'd3
  } ieq_req_e;

  // One request as taken from the request channel
  typedef struct packed {
    ieq_req_e           req_type;
    logic [7:0]         key_code;
    logic [7:0]         key_char;
    logic [6:0]         key_mods;
    logic signed [8:0]  move_x;
    logic signed [8:0]  move_y;
    logic [4:0]         button_state;
    logic [4:0]         button_delta;
    logic [31:0]        time_stamp;
  } ieq_req_t;

  // One stored event: stamp and payload
  typedef struct packed {
    logic [31:0]        ev_time;
    logic [31:0]        ev_seq;
    logic               kind;
    logic [7:0]         key;
    logic [7:0]         chr;
    logic [6:0]         mods;
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic [4:0]         buttons;
    logic [4:0]         changes;
  } ieq_entry_t;

  // Storage strobes from the control unit
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ieq_mem_ctl_t;

  // Result status of one request
  typedef struct packed {
    logic               popped;
    logic [COUNT_W-1:0] queue_count;
  } ieq_status_t;

endpackage

// ===== rtl/ieq_if.sv =====
`timescale 1ns / 1ps
// Interfaces: request and response channels of the input event ring queue.
interface ieq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [7:0]        key_code;
  logic [7:0]        key_char;
  logic [6:0]        key_mods;
  logic signed [8:0] move_x;
  logic signed [8:0] move_y;
  logic [4:0]        button_state;
  logic [4:0]        button_delta;
  logic [31:0]       time_stamp;

  modport source (
    output valid, req_type, key_code, key_char, key_mods, move_x, move_y,
           button_state, button_delta, time_stamp,
    input  ready
  );
  modport sink (
    input  valid, req_type, key_code, key_char, key_mods, move_x, move_y,
           button_state, button_delta, time_stamp,
    output ready
  );
endinterface

interface ieq_rsp_if;
  logic              valid;
  logic              ready;
  logic              popped;
  logic              ev_kind;
  logic [31:0]       ev_time;
  logic [31:0]       ev_seq;
  logic [7:0]        ev_key;
  logic [7:0]        ev_char;
  logic [6:0]        ev_mods;
  logic signed [8:0] ev_dx;
  logic signed [8:0] ev_dy;
  logic [4:0]        ev_buttons;
  logic [4:0]        ev_changes;
  logic [6:0]        queue_count;

  modport source (
    output valid, popped, ev_kind, ev_time, ev_seq, ev_key, ev_char, ev_mods,
           ev_dx, ev_dy, ev_buttons, ev_changes, queue_count,
    input  ready
  );
  modport sink (
    input  valid, popped, ev_kind, ev_time, ev_seq, ev_key, ev_char, ev_mods,
           ev_dx, ev_dy, ev_buttons, ev_changes, queue_count,
    output ready
  );
endinterface

// ===== rtl/ieq_mem.sv =====
`timescale 1ns / 1ps
// Event storage: one write port, one registered read port.
module ieq_mem #(
  parameter int unsigned QUEUE_DEPTH = ieq_pkg::IEQ_DEPTH,
  parameter int unsigned AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk_i,
  input  ieq_pkg::ieq_mem_ctl_t ctl_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  ieq_pkg::ieq_entry_t  wr_data_i,
  input  logic [AW-1:0]        rd_addr_i,
  output ieq_pkg::ieq_entry_t  rd_data_o
);

  ieq_pkg::ieq_entry_t mem_q [QUEUE_DEPTH];
  ieq_pkg::ieq_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next pop so a stalled result stays intact
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/ieq_ctrl.sv =====
`timescale 1ns / 1ps
// Queue control: pointers, fill count, sequence counter and storage strobes.
module ieq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = ieq_pkg::IEQ_DEPTH,
  parameter int unsigned AW          = $clog2(QUEUE_DEPTH),
  parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  ieq_pkg::ieq_req_t     req_i,
  output ieq_pkg::ieq_mem_ctl_t mem_ctl_o,
  output logic [AW-1:0]         wr_addr_o,
  output ieq_pkg::ieq_entry_t   wr_data_o,
  output logic [AW-1:0]         rd_addr_o,
  output ieq_pkg::ieq_status_t  status_o
);

  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   seq_q, seq_d;
  logic          do_push;
  logic          full;
  logic          is_mouse;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full     = (count_q == CW'(QUEUE_DEPTH));
  assign is_mouse = (req_i.req_type == ieq_pkg::REQ_MOUSE);

  // Build the entry; fields of the other event kind store as zero
  always_comb begin
    wr_data_o         = '0;
    wr_data_o.ev_time = req_i.time_stamp;
    wr_data_o.ev_seq  = seq_q + 32'd1;
    wr_data_o.kind    = is_mouse;
    if (is_mouse) begin
      wr_data_o.dx      = req_i.move_x;
      wr_data_o.dy      = req_i.move_y;
      wr_data_o.buttons = req_i.button_state;
      wr_data_o.changes = req_i.button_delta;
    end else begin
      wr_data_o.key  = req_i.key_code;
      wr_data_o.chr  = req_i.key_char;
      wr_data_o.mods = req_i.key_mods;
    end
  end

  always_comb begin
    wr_ptr_d        = wr_ptr_q;
    rd_ptr_d        = rd_ptr_q;
    count_d         = count_q;
    seq_d           = seq_q;
    do_push         = 1'b0;
    mem_ctl_o       = '0;
    status_o.popped = 1'b0;
    if (accept_i) begin
      case (req_i.req_type)
        ieq_pkg::REQ_KEY: begin
          do_push = (req_i.key_code != 8'd0);
        end
        ieq_pkg::REQ_MOUSE: begin
          do_push = (req_i.move_x != 9'sd0) || (req_i.move_y != 9'sd0) ||
                    (req_i.button_delta != 5'd0);
        end
        ieq_pkg::REQ_POP: begin
          if (count_q != '0) begin
            mem_ctl_o.rd_en = 1'b1;
            status_o.popped = 1'b1;
            rd_ptr_d        = advance(rd_ptr_q);
            count_d         = count_q - CW'(1);
          end
        end
        ieq_pkg::REQ_CLEAR: begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          count_d  = '0;
        end
        default: ;
      endcase
    end
    if (do_push) begin
      mem_ctl_o.wr_en = 1'b1;
      seq_d           = seq_q + 32'd1;
      wr_ptr_d        = advance(wr_ptr_q);
      // Drop the oldest entry when full
      if (full) begin
        rd_ptr_d = advance(rd_ptr_q);
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    status_o.queue_count = ieq_pkg::COUNT_W'(count_d);
  end

  assign wr_addr_o = wr_ptr_q;
  assign rd_addr_o = rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      seq_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      seq_q    <= seq_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty queue with pointers apart");

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (rd_ptr_q == wr_ptr_q))
    else $error("full queue with pointers apart");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.wr_en |=> (seq_q == $past(seq_q) + 32'd1))
    else $error("sequence counter did not advance on push");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.wr_en && mem_ctl_o.rd_en))
    else $error("storage written and read for one request");

endmodule

// ===== rtl/input_event_ring_queue.sv =====
`timescale 1ns / 1ps
// Top level: input event ring queue with request and response channels.
//
// Event FIFO that stamps each accepted key or mouse push with its time stamp
// and a wrapping sequence number starting at 1, drops the oldest event when
// full, and answers every request (push, pop, clear) with exactly one
// response beat carrying the queue count after that request. One request is
// taken per clock cycle while the response slot is free: the pointer and count
// update and the single storage access (write on push, read on pop) happen at
// the edge that accepts the request, and the response beat is valid in the
// next cycle. Throughput is set by the response register; a new request is
// taken whenever the response register is empty or its beat is taken in the
// same cycle. No clearing pass runs after reset: a pop only reads entries
// written before, so the storage needs no initialization.
module input_event_ring_queue #(
  parameter int unsigned QUEUE_DEPTH = ieq_pkg::IEQ_DEPTH
) (
  input logic   clk_i,
  input logic   rst_ni,
  ieq_req_if.sink   req_i,
  ieq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  ieq_pkg::ieq_req_t     req;
  ieq_pkg::ieq_mem_ctl_t mem_ctl;
  ieq_pkg::ieq_entry_t   wr_data;
  ieq_pkg::ieq_entry_t   rd_data;
  ieq_pkg::ieq_status_t  status;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  accept;

  // Response register: valid flag under reset, status as plain payload
  logic                  rsp_valid_q;
  logic                  popped_q;
  logic [6:0]            count_q;

  // Take a new request when the response slot is free or drains this cycle
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Pack the request beat
  assign req.req_type     = ieq_pkg::ieq_req_e'(req_i.req_type);
  assign req.key_code     = req_i.key_code;
  assign req.key_char     = req_i.key_char;
  assign req.key_mods     = req_i.key_mods;
  assign req.move_x       = req_i.move_x;
  assign req.move_y       = req_i.move_y;
  assign req.button_state = req_i.button_state;
  assign req.button_delta = req_i.button_delta;
  assign req.time_stamp   = req_i.time_stamp;

  ieq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req),
    .mem_ctl_o (mem_ctl),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .status_o  (status)
  );

  // Storage read data is registered and held until the next pop, so it
  // lines up with the response register
  ieq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Load the response on accept; drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= status.popped;
      count_q  <= status.queue_count;
    end
  end

  // Event fields read as zero unless the request popped an event
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.popped      = popped_q;
  assign rsp_o.ev_kind     = popped_q ? rd_data.kind    : 1'b0;
  assign rsp_o.ev_time     = popped_q ? rd_data.ev_time : 32'd0;
  assign rsp_o.ev_seq      = popped_q ? rd_data.ev_seq  : 32'd0;
  assign rsp_o.ev_key      = popped_q ? rd_data.key     : 8'd0;
  assign rsp_o.ev_char     = popped_q ? rd_data.chr     : 8'd0;
  assign rsp_o.ev_mods     = popped_q ? rd_data.mods    : 7'd0;
  assign rsp_o.ev_dx       = popped_q ? rd_data.dx      : 9'sd0;
  assign rsp_o.ev_dy       = popped_q ? rd_data.dy      : 9'sd0;
  assign rsp_o.ev_buttons  = popped_q ? rd_data.buttons : 5'd0;
  assign rsp_o.ev_changes  = popped_q ? rd_data.changes : 5'd0;
  assign rsp_o.queue_count = count_q;

endmodule

// ===== tb/input_event_ring_queue_tb.sv =====
`timescale 1ns / 1ps
// Testbench: random and directed traffic with a predictor for the input event ring queue.
module input_event_ring_queue_tb;
  import ieq_pkg::*;

  localparam int unsigned DEPTH       = IEQ_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One response beat as the predictor works it out
  typedef struct packed {
    logic              popped;
    logic              ev_kind;
    logic [31:0]       ev_time;
    logic [31:0]       ev_seq;
    logic [7:0]        ev_key;
    logic [7:0]        ev_char;
    logic [6:0]        ev_mods;
    logic signed [8:0] ev_dx;
    logic signed [8:0] ev_dy;
    logic [4:0]        ev_buttons;
    logic [4:0]        ev_changes;
    logic [6:0]        queue_count;
  } event_beat_t;

  logic clk_i;
  logic rst_ni;

  ieq_req_if req_if ();
  ieq_rsp_if rsp_if ();

  input_event_ring_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Requests still to be offered, and beats still owed by the block
  ieq_req_t    requests_todo[$];
  event_beat_t beats_owed[$];

  // Percent of cycles in which the sender or the receiver holds back
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  int unsigned mismatches;
  int unsigned cycles;

  // Shadow copy of the event ring
  ieq_entry_t  ring_slots[DEPTH];
  int unsigned ring_wr;
  int unsigned ring_rd;
  int unsigned ring_fill;
  logic [31:0] ring_seq;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one accepted request to the shadow ring and return the beat it owes.
  function automatic event_beat_t ring_apply(input ieq_req_t r);
    event_beat_t beat;
    ieq_entry_t  ev;
    logic        store;
    beat  = '0;
    ev    = '0;
    store = 1'b0;
    case (r.req_type)
      REQ_KEY: begin
        ev.kind = 1'b0;
        ev.key  = r.key_code;
        ev.chr  = r.key_char;
        ev.mods = r.key_mods;
        // a key beat without a key code is dropped on the floor
        store   = (r.key_code != '0);
      end
      REQ_MOUSE: begin
        ev.kind    = 1'b1;
        ev.dx      = r.move_x;
        ev.dy      = r.move_y;
        ev.buttons = r.button_state;
        ev.changes = r.button_delta;
        // button_state alone does not make a mouse beat count
        store      = (r.move_x != '0) || (r.move_y != '0) || (r.button_delta != '0);
      end
      REQ_POP: begin
        if (ring_fill != 0) begin
          ev              = ring_slots[ring_rd];
          beat.popped     = 1'b1;
          beat.ev_kind    = ev.kind;
          beat.ev_time    = ev.ev_time;
          beat.ev_seq     = ev.ev_seq;
          beat.ev_key     = ev.key;
          beat.ev_char    = ev.chr;
          beat.ev_mods    = ev.mods;
          beat.ev_dx      = ev.dx;
          beat.ev_dy      = ev.dy;
          beat.ev_buttons = ev.buttons;
          beat.ev_changes = ev.changes;
          ring_rd         = (ring_rd + 1) % DEPTH;
          ring_fill--;
        end
      end
      default: begin
        // clear empties the ring but keeps the sequence count
        ring_wr   = 0;
        ring_rd   = 0;
        ring_fill = 0;
      end
    endcase
    if (store) begin
      // full: drop the oldest event to make room
      if (ring_fill >= DEPTH) begin
        ring_rd = (ring_rd + 1) % DEPTH;
        ring_fill--;
      end
      ring_seq            = ring_seq + 32'd1;
      ev.ev_time          = r.time_stamp;
      ev.ev_seq           = ring_seq;
      ring_slots[ring_wr] = ev;
      ring_wr             = (ring_wr + 1) % DEPTH;
      ring_fill++;
    end
    beat.queue_count = ring_fill[6:0];
    return beat;
  endfunction

  function automatic ieq_req_t random_request(input ieq_req_e kind);
    ieq_req_t r;
    r.req_type     = kind;
    r.key_code     = 8'($urandom);
    r.key_char     = 8'($urandom);
    r.key_mods     = 7'($urandom);
    r.move_x       = 9'($urandom);
    r.move_y       = 9'($urandom);
    r.button_state = 5'($urandom);
    r.button_delta = 5'($urandom);
    r.time_stamp   = $urandom;
    // now and then, make a push that the block has to ignore
    if (kind == REQ_KEY && $urandom_range(19) == 0) begin
      r.key_code = '0;
    end
    if (kind == REQ_MOUSE && $urandom_range(19) == 0) begin
      r.move_x       = '0;
      r.move_y       = '0;
      r.button_delta = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Queue bursts of random requests until the target count is reached.
  task automatic queue_random(input int unsigned target);
    int unsigned counted;
    int unsigned burst;
    int unsigned push_pct;
    ieq_req_e    kind;
    ieq_req_t    r;
    counted = 0;
    while (counted < target) begin
      burst = $urandom_range(100, 20);
      // pick a burst flavor: fill past full, drain, or mixed
      case ($urandom_range(3))
        0:       push_pct = 100;
        1:       push_pct = 85;
        2:       push_pct = 15;
        default: push_pct = 50;
      endcase
      while (burst != 0 && counted < target) begin
        if ($urandom_range(199) == 0) begin
          kind = REQ_CLEAR;
        end else if ($urandom_range(99) < push_pct) begin
          kind = $urandom_range(1) ? REQ_MOUSE : REQ_KEY;
        end else begin
          kind = REQ_POP;
        end
        r = random_request(kind);
        requests_todo.push_back(r);
        counted++;
        burst--;
      end
    end
  endtask

  // Hold until every request has gone out and every owed beat has come back.
  task automatic wait_drained();
    while (requests_todo.size() != 0 || req_if.valid || beats_owed.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver: when the channel slot is free, present the next request unless the sender holds back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.req_type     <= REQ_KEY;
      req_if.key_code     <= '0;
      req_if.key_char     <= '0;
      req_if.key_mods     <= '0;
      req_if.move_x       <= '0;
      req_if.move_y       <= '0;
      req_if.button_state <= '0;
      req_if.button_delta <= '0;
      req_if.time_stamp   <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (requests_todo.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
        ieq_req_t nxt;
        nxt = requests_todo.pop_front();
        req_if.valid        <= 1'b1;
        req_if.req_type     <= nxt.req_type;
        req_if.key_code     <= nxt.key_code;
        req_if.key_char     <= nxt.key_char;
        req_if.key_mods     <= nxt.key_mods;
        req_if.move_x       <= nxt.move_x;
        req_if.move_y       <= nxt.move_y;
        req_if.button_state <= nxt.button_state;
        req_if.button_delta <= nxt.button_delta;
        req_if.time_stamp   <= nxt.time_stamp;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each response beat against the oldest owed beat, then
  // record the request accepted at this edge. Doing both in one block keeps
  // the order fixed within the time step.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (beats_owed.size() == 0) begin
          mismatches++;
          $display("%0t: response beat with none owed, expected no beat, actual count %h",
                   $time, rsp_if.queue_count);
        end else begin
          event_beat_t want;
          want = beats_owed.pop_front();
          check_field("popped",      32'(want.popped),      32'(rsp_if.popped));
          check_field("ev_kind",     32'(want.ev_kind),     32'(rsp_if.ev_kind));
          check_field("ev_time",     want.ev_time,          rsp_if.ev_time);
          check_field("ev_seq",      want.ev_seq,           rsp_if.ev_seq);
          check_field("ev_key",      32'(want.ev_key),      32'(rsp_if.ev_key));
          check_field("ev_char",     32'(want.ev_char),     32'(rsp_if.ev_char));
          check_field("ev_mods",     32'(want.ev_mods),     32'(rsp_if.ev_mods));
          check_field("ev_dx",       32'(want.ev_dx),       32'(rsp_if.ev_dx));
          check_field("ev_dy",       32'(want.ev_dy),       32'(rsp_if.ev_dy));
          check_field("ev_buttons",  32'(want.ev_buttons),  32'(rsp_if.ev_buttons));
          check_field("ev_changes",  32'(want.ev_changes),  32'(rsp_if.ev_changes));
          check_field("queue_count", 32'(want.queue_count), 32'(rsp_if.queue_count));
        end
      end
      if (req_if.valid && req_if.ready) begin
        ieq_req_t seen;
        seen.req_type     = ieq_req_e'(req_if.req_type);
        seen.key_code     = req_if.key_code;
        seen.key_char     = req_if.key_char;
        seen.key_mods     = req_if.key_mods;
        seen.move_x       = req_if.move_x;
        seen.move_y       = req_if.move_y;
        seen.button_state = req_if.button_state;
        seen.button_delta = req_if.button_delta;
        seen.time_stamp   = req_if.time_stamp;
        beats_owed.push_back(ring_apply(seen));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cycles       = 0;
    mismatches   = 0;
    ring_wr      = 0;
    ring_rd      = 0;
    ring_fill    = 0;
    ring_seq     = '0;
    req_idle_pct = 26;
    rsp_idle_pct = 57;
    // drive every block input to a known value before the first edge
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_KEY;
    req_if.key_code     = '0;
    req_if.key_char     = '0;
    req_if.key_mods     = '0;
    req_if.move_x       = '0;
    req_if.move_y       = '0;
    req_if.button_state = '0;
    req_if.button_delta = '0;
    req_if.time_stamp   = '0;
    rsp_if.ready        = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening: empty pop, ignored pushes, field extremes, clear.
    requests_todo.push_back('{REQ_POP, 8'h00, 8'h00, 7'h00, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'h0000_0000});
    requests_todo.push_back('{REQ_KEY, 8'h00, 8'hFF, 7'h7F, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'h1234_5678});
    requests_todo.push_back('{REQ_MOUSE, 8'hFF, 8'h00, 7'h00, 9'h000, 9'h000,
                              5'h1F, 5'h00, 32'h0000_0001});
    requests_todo.push_back('{REQ_KEY, 8'hFF, 8'hFF, 7'h7F, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'hFFFF_FFFF});
    requests_todo.push_back('{REQ_KEY, 8'h01, 8'h00, 7'h00, 9'h1FF, 9'h1FF,
                              5'h1F, 5'h1F, 32'h0000_0000});
    requests_todo.push_back('{REQ_MOUSE, 8'h00, 8'h00, 7'h00, 9'h100, 9'h0FF,
                              5'h1F, 5'h00, 32'h8000_0000});
    requests_todo.push_back('{REQ_MOUSE, 8'h00, 8'h00, 7'h00, 9'h000, 9'h000,
                              5'h00, 5'h01, 32'h7FFF_FFFF});
    requests_todo.push_back('{REQ_MOUSE, 8'h00, 8'h00, 7'h00, 9'h0FF, 9'h100,
                              5'h00, 5'h1F, 32'hAAAA_5555});
    repeat (5) begin
      requests_todo.push_back('{REQ_POP, 8'hFF, 8'hFF, 7'h7F, 9'h1FF, 9'h1FF,
                                5'h1F, 5'h1F, 32'hFFFF_FFFF});
    end
    requests_todo.push_back('{REQ_KEY, 8'h41, 8'h61, 7'h01, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'h0000_0100});
    requests_todo.push_back('{REQ_CLEAR, 8'h00, 8'h00, 7'h00, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'h0000_0000});
    requests_todo.push_back('{REQ_POP, 8'h00, 8'h00, 7'h00, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'h0000_0000});
    requests_todo.push_back('{REQ_KEY, 8'h80, 8'h0A, 7'h40, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'h0000_0200});
    requests_todo.push_back('{REQ_POP, 8'h00, 8'h00, 7'h00, 9'h000, 9'h000,
                              5'h00, 5'h00, 32'h0000_0000});
    requests_todo.push_back('{REQ_CLEAR, 8'hFF, 8'hFF, 7'h7F, 9'h1FF, 9'h1FF,
                              5'h1F, 5'h1F, 32'hFFFF_FFFF});

    // Three phases of random traffic; the sender pauses between them until
    // every owed beat has come back.
    queue_random(580);
    wait_drained();

    req_idle_pct = 57;
    rsp_idle_pct = 26;
    queue_random(580);
    wait_drained();

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    queue_random(590);
    wait_drained();

    // let any stray beat show up before the verdict
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && beats_owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
